// ===== src/ljw_pkg.sv =====
package ljw_pkg;

    // table sizes
    localparam int MAX_WALLS = 8;
    localparam int NUM_TYPES = 16;
    localparam int WALL_W    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W     = $clog2(MAX_WALLS + 1);
    localparam int TYPE_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    // reciprocal unit: quotient bits, bits per stage, register stages
    localparam int QBITS   = 28;
    localparam int QSTEP   = 4;
    localparam int RCP_LAT = QBITS / QSTEP + 1;

    // float constants
    localparam logic [31:0] F_TWELVE = 32'h4140_0000;
    localparam logic [31:0] F_SIX    = 32'h40C0_0000;
    localparam logic [31:0] F_QNAN   = 32'hFFC0_0000;
    localparam logic [31:0] F_QBIT   = 32'h0040_0000;

    // item kinds on tuser
    typedef enum logic [1:0] {
        FN_PART = 2'd0,
        FN_WALL = 2'd1,
        FN_TYPE = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [3:0] {
        CFG_CUTOFF = 4'd0,
        CFG_NWALLS = 4'd1,
        CFG_XLO    = 4'd2,
        CFG_XHI    = 4'd3,
        CFG_YLO    = 4'd4,
        CFG_YHI    = 4'd5,
        CFG_ZLO    = 4'd6,
        CFG_ZHI    = 4'd7
    } cfg_idx_t;

    function automatic logic f_isnan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // leading zero count, value left aligned in 48 bits
    function automatic logic [5:0] f_clz48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

    // round to nearest even; sig has its leading one at bit 26
    function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] e,
                                            input logic [26:0] sig, input logic stk);
        logic [26:0] m;
        logic        st;
        logic [11:0] sh;
        logic [7:0]  ef;
        logic        rnd;
        logic [30:0] mag;
        m  = sig;
        st = stk;
        ef = 8'd0;
        if (e >= 12'sd255)
            return {s, 8'hFF, 23'd0};
        if (e <= 12'sd0) begin
            sh = 12'(12'sd1 - e);
            if (sh > 12'd27)
                sh = 12'd27;
            st = st | (|(m & ((27'd1 << sh) - 27'd1)));
            m  = m >> sh;
        end else begin
            ef = e[7:0];
        end
        rnd = m[2] && (m[1] || m[0] || st || m[3]);
        mag = {ef, m[25:3]} + 31'(rnd);
        return {s, mag};
    endfunction

    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               a_inf, b_inf, a_zero, b_zero;
        logic [23:0]        ma, mb;
        logic signed [11:0] ea, eb, e;
        logic [47:0]        p, pn;
        logic [5:0]         lz;
        s      = a[31] ^ b[31];
        a_inf  = (a[30:0] == 31'h7F80_0000);
        b_inf  = (b[30:0] == 31'h7F80_0000);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (f_isnan(a))
            return a | F_QBIT;
        if (f_isnan(b))
            return b | F_QBIT;
        if ((a_inf && b_zero) || (b_inf && a_zero))
            return F_QNAN;
        if (a_inf || b_inf)
            return {s, 8'hFF, 23'd0};
        if (a_zero || b_zero)
            return {s, 31'd0};
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
        eb = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
        p  = ma * mb;
        lz = f_clz48(p);
        pn = p << lz;
        e  = ea + eb - 12'sd126 - $signed({6'd0, lz});
        return f_round(s, e, pn[47:21], |pn[20:0]);
    endfunction

    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x, y;
        logic [23:0]        mx, my;
        logic [7:0]         ex, ey, d;
        logic [26:0]        xs, y0, ys;
        logic [27:0]        sum, sn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        if (f_isnan(a))
            return a | F_QBIT;
        if (f_isnan(b))
            return b | F_QBIT;
        if ((a[30:0] == 31'h7F80_0000) && (b[30:0] == 31'h7F80_0000) && (a[31] != b[31]))
            return F_QNAN;
        if (a[30:0] == 31'h7F80_0000)
            return a;
        if (b[30:0] == 31'h7F80_0000)
            return b;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return {a[31] & b[31], 31'd0};
        // larger magnitude first
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        mx = {(x[30:23] != 8'd0), x[22:0]};
        my = {(y[30:23] != 8'd0), y[22:0]};
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        if (d > 8'd27)
            d = 8'd27;
        xs = {mx, 3'b000};
        y0 = {my, 3'b000};
        ys = y0 >> d;
        ys[0] = ys[0] | (|(y0 & ((27'd1 << d) - 27'd1)));
        if (x[31] ^ y[31])
            sum = {1'b0, xs} - {1'b0, ys};
        else
            sum = {1'b0, xs} + {1'b0, ys};
        if (sum == 28'd0)
            return 32'd0;
        lz = f_clz48({sum, 20'd0});
        sn = sum << lz;
        e  = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
        return f_round(x[31], e, sn[27:1], sn[0]);
    endfunction

    function automatic logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
        if (f_isnan(b))
            return f_add(a, b);
        return f_add(a, {~b[31], b[30:0]});
    endfunction

    // ordered less-than; false on any nan
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka, kb;
        if (f_isnan(a) || f_isnan(b))
            return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return 1'b0;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        return ka < kb;
    endfunction

endpackage

// ===== src/ljw_recip.sv =====
module ljw_recip (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x,
    output logic [31:0] y
);
    import ljw_pkg::*;

    localparam int NQS = QBITS / QSTEP;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spv;
        logic               s;
        logic signed [11:0] ex;
        logic [23:0]        m;
        logic [24:0]        rem;
        logic [QBITS-1:0]   q;
    } rcp_stage_t;

    rcp_stage_t st_reg [0:NQS];
    rcp_stage_t st_next [0:NQS];

    logic [23:0]        mant;
    logic [5:0]         lz;
    logic signed [11:0] e_out;
    logic [26:0]        sig;
    logic               stk;

    // unpack, specials and normalization of subnormal inputs
    always_comb
    begin
        mant = {(x[30:23] != 8'd0), x[22:0]};
        lz   = f_clz48({mant, 24'd0});
        st_next[0].s    = x[31];
        st_next[0].spec = 1'b0;
        st_next[0].spv  = 32'd0;
        st_next[0].rem  = 25'(1) << 23;
        st_next[0].q    = '0;
        if (x[30:23] == 8'd0) begin
            st_next[0].m  = mant << lz;
            st_next[0].ex = 12'sd1 - $signed({6'd0, lz});
        end else begin
            st_next[0].m  = mant;
            st_next[0].ex = $signed({4'd0, x[30:23]});
        end
        if (f_isnan(x)) begin
            st_next[0].spec = 1'b1;
            st_next[0].spv  = x | F_QBIT;
        end else if (x[30:0] == 31'd0) begin
            st_next[0].spec = 1'b1;
            st_next[0].spv  = {x[31], 8'hFF, 23'd0};
        end else if (x[30:23] == 8'hFF) begin
            st_next[0].spec = 1'b1;
            st_next[0].spv  = {x[31], 31'd0};
        end
    end

    // restoring division steps, QSTEP quotient bits per stage
    always_comb
    begin
        for (int i = 1; i <= NQS; i++) begin
            st_next[i] = st_reg[i-1];
            for (int j = 0; j < QSTEP; j++) begin
                if (st_next[i].rem >= {1'b0, st_next[i].m}) begin
                    st_next[i].q   = {st_next[i].q[QBITS-2:0], 1'b1};
                    st_next[i].rem = st_next[i].rem - {1'b0, st_next[i].m};
                end else begin
                    st_next[i].q = {st_next[i].q[QBITS-2:0], 1'b0};
                end
                st_next[i].rem = {st_next[i].rem[23:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int i = 0; i <= NQS; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // final normalize and round
    always_comb
    begin
        stk = (st_reg[NQS].rem != 25'd0);
        if (st_reg[NQS].q[QBITS-1]) begin
            e_out = 12'sd254 - st_reg[NQS].ex;
            sig   = st_reg[NQS].q[QBITS-1:1];
            stk   = stk | st_reg[NQS].q[0];
        end else begin
            e_out = 12'sd253 - st_reg[NQS].ex;
            sig   = st_reg[NQS].q[QBITS-2:0];
        end
        if (st_reg[NQS].spec)
            y = st_reg[NQS].spv;
        else
            y = f_round(st_reg[NQS].s, e_out, sig, stk);
    end

endmodule

// ===== src/lj_wall_force_core.sv =====
// Lennard-Jones wall force engine, IEEE single precision throughout. Wall and
// type-coefficient loads give no result. A particle occupies the wall issue slot
// for max(num_walls, 1) issues, one particle-wall pair per cycle while the
// pipeline is not stalled, and the next item is taken on the last issue cycle.
// Its result appears after its last pair has passed the float stages to the
// squared distance, an eight-stage radix-16 reciprocal, eight more stages to
// the force terms and a registered in-order accumulator. The pipeline stalls
// only when a finished result waits at the output and another one is due.
module lj_wall_force_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, coeff_a, coeff_b, zero pad
    input  logic [263:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z, energy
    output logic [127:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ljw_pkg::*;

    localparam int NST = 19;
    localparam int RCP_IN = 10;
    localparam int RCP_OUT = 11;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             pair;
        logic             hit;
        logic [2:0][31:0] p;
        logic [2:0][31:0] o;
        logic [2:0][31:0] n;
        logic [31:0]      ca;
        logic [31:0]      cb;
    } tok_t;

    // input fields
    logic [3:0]       in_slot;
    logic [2:0][31:0] in_pos, in_dir;
    logic [31:0]      in_ca, in_cb;
    func_t            in_func;

    assign in_slot   = s_tdata[3:0];
    assign in_pos[0] = s_tdata[35:4];
    assign in_pos[1] = s_tdata[67:36];
    assign in_pos[2] = s_tdata[99:68];
    assign in_dir[0] = s_tdata[131:100];
    assign in_dir[1] = s_tdata[163:132];
    assign in_dir[2] = s_tdata[195:164];
    assign in_ca     = s_tdata[227:196];
    assign in_cb     = s_tdata[259:228];
    assign in_func   = func_t'(s_tuser);

    // configuration registers
    logic [31:0]      cutoff_reg;
    logic [3:0]       nwalls_reg;
    logic [2:0][31:0] box_lo_reg, box_hi_reg;
    logic [2:0][31:0] len_reg;
    logic [31:0]      rcsq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cutoff_reg <= '0;
            nwalls_reg <= '0;
            box_lo_reg <= '0;
            box_hi_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CUTOFF: cutoff_reg    <= cfg_data;
                CFG_NWALLS: nwalls_reg    <= cfg_data[3:0];
                CFG_XLO:    box_lo_reg[0] <= cfg_data;
                CFG_XHI:    box_hi_reg[0] <= cfg_data;
                CFG_YLO:    box_lo_reg[1] <= cfg_data;
                CFG_YHI:    box_hi_reg[1] <= cfg_data;
                CFG_ZLO:    box_lo_reg[2] <= cfg_data;
                CFG_ZHI:    box_hi_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // derived box lengths and squared cutoff
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
            len_reg[j] <= f_sub(box_hi_reg[j], box_lo_reg[j]);
        rcsq_reg <= f_mul(cutoff_reg, cutoff_reg);
    end

    // wall and type tables
    logic [2:0][31:0] wall_o_reg [MAX_WALLS];
    logic [2:0][31:0] wall_n_reg [MAX_WALLS];
    logic [31:0]      type_a_reg [NUM_TYPES];
    logic [31:0]      type_b_reg [NUM_TYPES];

    // pipeline control and issue state
    logic             adv;
    logic             in_acc;
    logic             busy_reg, busy_next;
    logic             pair_reg, pair_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] nw_reg, nw_next;
    logic [CNT_W-1:0] nw_sat;
    logic             last_iss;
    logic [2:0][31:0] cur_p_reg, cur_p_next;
    logic [31:0]      cur_a_reg, cur_a_next, cur_b_reg, cur_b_next;

    tok_t tk_reg [NST];
    tok_t tk_next [NST];
    tok_t dl_reg [RCP_LAT];
    logic [31:0] rcp_y;

    logic        out_valid_reg;
    logic [3:0][31:0] out_data_reg;
    logic [3:0][31:0] acc_reg, acc_next;

    assign adv = !(out_valid_reg && !m_tready && tk_reg[NST-1].vld && tk_reg[NST-1].last);
    assign last_iss = busy_reg && (CNT_W'(k_reg + 1'b1) == nw_reg);
    assign s_tready = adv && (!busy_reg || last_iss);
    assign in_acc = s_tvalid && s_tready;
    assign nw_sat = (int'(nwalls_reg) > MAX_WALLS) ? CNT_W'(MAX_WALLS) : CNT_W'(nwalls_reg);

    // table writes from load items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_WALLS; i++) begin
                wall_o_reg[i] <= '0;
                wall_n_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TYPES; i++) begin
                type_a_reg[i] <= '0;
                type_b_reg[i] <= '0;
            end
        end else if (in_acc) begin
            if ((in_func == FN_WALL) && (int'(in_slot) < MAX_WALLS)) begin
                wall_o_reg[in_slot[WALL_W-1:0]] <= in_pos;
                wall_n_reg[in_slot[WALL_W-1:0]] <= in_dir;
            end
            if ((in_func == FN_TYPE) && (int'(in_slot) < NUM_TYPES)) begin
                type_a_reg[in_slot[TYPE_W-1:0]] <= in_ca;
                type_b_reg[in_slot[TYPE_W-1:0]] <= in_cb;
            end
        end
    end

    // wall issue sequencer
    always_comb
    begin
        busy_next  = busy_reg;
        pair_next  = pair_reg;
        k_next     = k_reg;
        nw_next    = nw_reg;
        cur_p_next = cur_p_reg;
        cur_a_next = cur_a_reg;
        cur_b_next = cur_b_reg;
        if (busy_reg) begin
            k_next = CNT_W'(k_reg + 1'b1);
            if (last_iss)
                busy_next = 1'b0;
        end
        if (in_acc && (in_func == FN_PART)) begin
            busy_next  = 1'b1;
            k_next     = '0;
            nw_next    = (nw_sat == '0) ? CNT_W'(1) : nw_sat;
            pair_next  = (nw_sat != '0);
            cur_p_next = in_pos;
            if (int'(in_slot) < NUM_TYPES) begin
                cur_a_next = type_a_reg[in_slot[TYPE_W-1:0]];
                cur_b_next = type_b_reg[in_slot[TYPE_W-1:0]];
            end else begin
                cur_a_next = '0;
                cur_b_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            pair_reg <= 1'b0;
            k_reg    <= '0;
            nw_reg   <= '0;
        end else if (adv) begin
            busy_reg <= busy_next;
            pair_reg <= pair_next;
            k_reg    <= k_next;
            nw_reg   <= nw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            cur_p_reg <= cur_p_next;
            cur_a_reg <= cur_a_next;
            cur_b_reg <= cur_b_next;
        end
    end

    // float pipeline stages
    always_comb
    begin
        // issue one particle-wall pair
        tk_next[0].vld   = busy_reg;
        tk_next[0].first = (k_reg == '0);
        tk_next[0].last  = last_iss;
        tk_next[0].pair  = pair_reg;
        tk_next[0].hit   = 1'b0;
        tk_next[0].p     = cur_p_reg;
        tk_next[0].o     = wall_o_reg[k_reg[WALL_W-1:0]];
        tk_next[0].n     = wall_n_reg[k_reg[WALL_W-1:0]];
        tk_next[0].ca    = cur_a_reg;
        tk_next[0].cb    = cur_b_reg;

        for (int i = 1; i < NST; i++)
            tk_next[i] = tk_reg[i-1];
        tk_next[RCP_OUT] = dl_reg[RCP_LAT-1];

        // offset from wall origin
        for (int j = 0; j < 3; j++)
            tk_next[1].p[j] = f_sub(tk_reg[0].p[j], tk_reg[0].o[j]);
        // projection terms
        for (int j = 0; j < 3; j++)
            tk_next[2].p[j] = f_mul(tk_reg[1].n[j], tk_reg[1].p[j]);
        // signed distance
        tk_next[3].p[0] = f_add(tk_reg[2].p[0], tk_reg[2].p[1]);
        tk_next[4].p[0] = f_add(tk_reg[3].p[0], tk_reg[3].p[2]);
        // displacement along the normal
        for (int j = 0; j < 3; j++)
            tk_next[5].p[j] = f_mul(tk_reg[4].n[j], tk_reg[4].p[0]);
        // periodic wrap, once per axis
        for (int j = 0; j < 3; j++) begin
            if (!f_lt(tk_reg[5].p[j], box_hi_reg[j]) && !f_isnan(tk_reg[5].p[j])
                && !f_isnan(box_hi_reg[j]))
                tk_next[6].p[j] = f_sub(tk_reg[5].p[j], len_reg[j]);
            else if (f_lt(tk_reg[5].p[j], box_lo_reg[j]))
                tk_next[6].p[j] = f_add(tk_reg[5].p[j], len_reg[j]);
        end
        // squared distance
        for (int j = 0; j < 3; j++)
            tk_next[7].o[j] = f_mul(tk_reg[6].p[j], tk_reg[6].p[j]);
        tk_next[8].o[0] = f_add(tk_reg[7].o[0], tk_reg[7].o[1]);
        tk_next[9].o[0] = f_add(tk_reg[8].o[0], tk_reg[8].o[2]);
        // cutoff test
        tk_next[RCP_IN].hit = f_lt(tk_reg[9].o[0], rcsq_reg);
        // after the reciprocal: 1/r2 and scaled coefficients
        tk_next[RCP_OUT].o[0] = rcp_y;
        tk_next[RCP_OUT].o[1] = f_mul(F_TWELVE, dl_reg[RCP_LAT-1].ca);
        tk_next[RCP_OUT].o[2] = f_mul(F_SIX, dl_reg[RCP_LAT-1].cb);
        // 1/r6
        tk_next[12].n[0] = f_mul(tk_reg[11].o[0], tk_reg[11].o[0]);
        tk_next[13].n[0] = f_mul(tk_reg[12].n[0], tk_reg[12].o[0]);
        // force and energy factors
        tk_next[14].n[1] = f_mul(tk_reg[13].o[1], tk_reg[13].n[0]);
        tk_next[14].n[2] = f_mul(tk_reg[13].ca, tk_reg[13].n[0]);
        tk_next[15].n[1] = f_sub(tk_reg[14].n[1], tk_reg[14].o[2]);
        tk_next[15].n[2] = f_sub(tk_reg[14].n[2], tk_reg[14].cb);
        tk_next[16].n[1] = f_mul(tk_reg[15].n[0], tk_reg[15].n[1]);
        tk_next[16].n[2] = f_mul(tk_reg[15].n[0], tk_reg[15].n[2]);
        tk_next[17].n[1] = f_mul(tk_reg[16].n[1], tk_reg[16].o[0]);
        // force components
        for (int j = 0; j < 3; j++)
            tk_next[18].o[j] = f_mul(tk_reg[17].p[j], tk_reg[17].n[1]);
    end

    ljw_recip u_recip (
        .clk (clk),
        .en  (adv),
        .x   (tk_reg[RCP_IN].o[0]),
        .y   (rcp_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NST; i++)
                tk_reg[i] <= '0;
            for (int i = 0; i < RCP_LAT; i++)
                dl_reg[i] <= '0;
        end else if (adv) begin
            for (int i = 0; i < NST; i++)
                tk_reg[i] <= tk_next[i];
            dl_reg[0] <= tk_reg[RCP_IN];
            for (int i = 1; i < RCP_LAT; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    // in-order accumulation over the walls of one particle
    always_comb
    begin
        for (int j = 0; j < 4; j++) begin
            acc_next[j] = tk_reg[NST-1].first ? 32'd0 : acc_reg[j];
            if (tk_reg[NST-1].pair && tk_reg[NST-1].hit) begin
                if (j < 3)
                    acc_next[j] = f_add(acc_next[j], tk_reg[NST-1].o[j]);
                else
                    acc_next[j] = f_add(acc_next[j], tk_reg[NST-1].n[2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tk_reg[NST-1].vld)
            acc_reg <= acc_next;
        if (adv && tk_reg[NST-1].vld && tk_reg[NST-1].last)
            out_data_reg <= acc_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (adv && tk_reg[NST-1].vld && tk_reg[NST-1].last)
                out_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (nw_reg != '0) && (k_reg < nw_reg))
        else $error("issue counter outside wall range");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && tk_reg[NST-1].vld && tk_reg[NST-1].last) |=> out_valid_reg)
        else $error("finished particle not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(tk_reg[NST-1]) && out_valid_reg)
        else $error("pipeline moved during stall");

endmodule
